/* src/dpbp_pkg.sv */
// ----------------------------------------------------------------------------
// Depth pixel back-projection: shared package
// Widths, configuration defaults, register indexes, divider lane types and
// the one-bit restoring divide step used by the divider.
// ----------------------------------------------------------------------------
package dpbp_pkg;

    localparam int MAX_IMAGE_SIDE = 4096;

    localparam int PIX_W      = 12;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int FOCAL_W    = 16;
    localparam int CENTER_W   = 16;
    localparam int SCALE_W    = 24;
    localparam int PROD_W     = DEPTH_W + SCALE_W;   // raw * scale, Q16.24
    localparam int Z_W        = 32;                  // Q16.16
    localparam int DMAG_W     = 16;                  // |pix*16 - center|, Q.4
    localparam int MUL_W      = DMAG_W + Z_W;        // Q.20
    localparam int NUM_W      = MUL_W + 1;           // numerator with rounding term
    localparam int REM_W      = FOCAL_W + 1;
    localparam int XY_W       = 45;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 152;
    localparam int M_USED_W   = 2 * XY_W + Z_W + 3 * COLOR_W;

    localparam logic [FOCAL_W-1:0]  FOCAL_X_RST     = 16'd9600;
    localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST     = 16'd9600;
    localparam logic [CENTER_W-1:0] CENTER_X_RST    = 16'd5120;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 16'd3840;
    localparam logic [SCALE_W-1:0]  DEPTH_SCALE_RST = 24'd16777;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X     = 3'd0,
        REG_FOCAL_Y     = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_DEPTH_SCALE = 3'd4
    } cfg_reg_t;

    // acc shifts dividend bits out at the top and quotient bits in at the bottom
    typedef struct packed {
        logic [NUM_W-1:0] acc;
        logic [REM_W-1:0] rem;
    } div_lane_t;

    typedef struct packed {
        logic [Z_W-1:0]     z;
        logic               neg_x;
        logic               neg_y;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pt_side_t;

    typedef struct packed {
        div_lane_t x;
        div_lane_t y;
        pt_side_t  side;
    } div_stage_t;

    function automatic div_lane_t div_step(div_lane_t a, logic [FOCAL_W-1:0] f);
        logic [REM_W-1:0] trial;
        logic [REM_W:0]   diff;
        div_lane_t        r;
        trial = {a.rem[REM_W-2:0], a.acc[NUM_W-1]};
        diff  = {1'b0, trial} - {2'b00, f};
        r.acc = {a.acc[NUM_W-2:0], ~diff[REM_W]};
        r.rem = diff[REM_W] ? trial : diff[REM_W-1:0];
        return r;
    endfunction

endpackage

/* src/dpbp_div_pipe.sv */
// ----------------------------------------------------------------------------
// Depth pixel back-projection: pipelined divider
// Two restoring dividers (x and y) side by side, one quotient bit per stage,
// with the point's side data carried alongside. Each stage holds or advances
// on its own, so bubbles close up under a stalled output.
// ----------------------------------------------------------------------------
module dpbp_div_pipe
    import dpbp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [FOCAL_W-1:0] focal_x,
    input  logic [FOCAL_W-1:0] focal_y,
    input  logic               in_valid,
    output logic               in_ready,
    input  div_stage_t         in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output div_stage_t         out_data
);

    logic       valid_reg [NUM_W];
    div_stage_t data_reg  [NUM_W];
    logic       stage_rdy [NUM_W+1];

    assign stage_rdy[NUM_W] = out_ready;

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic       prev_valid;
        div_stage_t prev_data;
        div_stage_t data_next;

        if (i == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_data  = in_data;
        end else begin : g_rest
            assign prev_valid = valid_reg[i-1];
            assign prev_data  = data_reg[i-1];
        end

        assign stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];

        always_comb begin
            data_next      = prev_data;
            data_next.x    = div_step(prev_data.x, focal_x);
            data_next.y    = div_step(prev_data.y, focal_y);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (stage_rdy[i]) begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_rdy[i] && prev_valid) begin
                data_reg[i] <= data_next;
            end
        end
    end

    assign in_ready  = stage_rdy[0];
    assign out_valid = valid_reg[NUM_W-1];
    assign out_data  = data_reg[NUM_W-1];

endmodule

/* src/depth_pixel_back_projection_unit.sv */
// ----------------------------------------------------------------------------
// Depth pixel back-projection unit
// Pipeline: 4 front stages, 49 divider stages, 1 output register.
// Throughput: one pixel per cycle while m_tready does not stall the output;
// the one-quotient-bit-per-stage divider pipeline sets the depth. Pixels with
// zero depth leave no point.
// Reset: aresetn (synchronous, active low) empties the pipeline and loads the
// default camera intrinsics and depth scale.
// ----------------------------------------------------------------------------
module depth_pixel_back_projection_unit
    import dpbp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // column, row, depth_raw, blue_in, green_in, red_in
    // point output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // point_x, point_y, point_z, red_out, green_out,
                                             // blue_out, zero pad
);

    localparam logic [NUM_W-1:0] XY_POS_MAX = NUM_W'((64'd1 << (XY_W - 1)) - 64'd1);
    localparam logic [NUM_W-1:0] XY_NEG_MAG = NUM_W'(64'd1 << (XY_W - 1));

    // configuration registers
    logic [FOCAL_W-1:0]  focal_x_reg;
    logic [FOCAL_W-1:0]  focal_y_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [SCALE_W-1:0]  depth_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg     <= FOCAL_X_RST;
            focal_y_reg     <= FOCAL_Y_RST;
            center_x_reg    <= CENTER_X_RST;
            center_y_reg    <= CENTER_Y_RST;
            depth_scale_reg <= DEPTH_SCALE_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_FOCAL_X:     focal_x_reg     <= cfg_wdata[FOCAL_W-1:0];
                REG_FOCAL_Y:     focal_y_reg     <= cfg_wdata[FOCAL_W-1:0];
                REG_CENTER_X:    center_x_reg    <= cfg_wdata[CENTER_W-1:0];
                REG_CENTER_Y:    center_y_reg    <= cfg_wdata[CENTER_W-1:0];
                REG_DEPTH_SCALE: depth_scale_reg <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // a zero focal length divides as one
    logic [FOCAL_W-1:0] fx_eff;
    logic [FOCAL_W-1:0] fy_eff;
    assign fx_eff = (focal_x_reg == '0) ? FOCAL_W'(1) : focal_x_reg;
    assign fy_eff = (focal_y_reg == '0) ? FOCAL_W'(1) : focal_y_reg;

    // input fields
    logic [PIX_W-1:0]   in_col;
    logic [PIX_W-1:0]   in_row;
    logic [DEPTH_W-1:0] in_depth;
    logic [COLOR_W-1:0] in_blue;
    logic [COLOR_W-1:0] in_green;
    logic [COLOR_W-1:0] in_red;
    assign in_col   = s_tdata[PIX_W-1:0];
    assign in_row   = s_tdata[2*PIX_W-1:PIX_W];
    assign in_depth = s_tdata[2*PIX_W+DEPTH_W-1:2*PIX_W];
    assign in_blue  = s_tdata[2*PIX_W+DEPTH_W+COLOR_W-1:2*PIX_W+DEPTH_W];
    assign in_green = s_tdata[2*PIX_W+DEPTH_W+2*COLOR_W-1:2*PIX_W+DEPTH_W+COLOR_W];
    assign in_red   = s_tdata[2*PIX_W+DEPTH_W+3*COLOR_W-1:2*PIX_W+DEPTH_W+2*COLOR_W];

    // stall chain: a stage takes new data when empty or when it drains
    logic       rdy1, rdy2, rdy3, rdy4;
    logic       div_in_ready;
    logic       div_out_valid;
    logic       div_out_ready;
    div_stage_t div_in;
    div_stage_t div_out;

    logic       v1_reg, v2_reg, v3_reg, v4_reg;

    assign rdy4     = !v4_reg || div_in_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // ---- stage 1: depth product, pixel offsets ----
    logic [CENTER_W-1:0] p16_x, p16_y;
    logic                in_range;
    logic [PROD_W-1:0]   prod1_reg;
    logic [DMAG_W-1:0]   dmag_x1_reg, dmag_y1_reg;
    pt_side_t            side1_reg;
    pt_side_t            side1_next;

    assign p16_x    = {in_col, 4'b0000};
    assign p16_y    = {in_row, 4'b0000};
    assign in_range = (32'(in_col) < 32'(MAX_IMAGE_SIDE)) && (32'(in_row) < 32'(MAX_IMAGE_SIDE));

    always_comb begin
        side1_next.z     = '0;
        side1_next.neg_x = p16_x < center_x_reg;
        side1_next.neg_y = p16_y < center_y_reg;
        side1_next.red   = in_red;
        side1_next.green = in_green;
        side1_next.blue  = in_blue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            prod1_reg   <= PROD_W'(in_depth) * PROD_W'(depth_scale_reg);
            dmag_x1_reg <= side1_next.neg_x ? (center_x_reg - p16_x) : (p16_x - center_x_reg);
            dmag_y1_reg <= side1_next.neg_y ? (center_y_reg - p16_y) : (p16_y - center_y_reg);
            side1_reg   <= side1_next;
        end
    end

    // ---- stage 2: round depth to Q16.16, drop zero depth ----
    logic [PROD_W:0]   zsum;
    logic [Z_W-1:0]    z_next;
    logic [DMAG_W-1:0] dmag_x2_reg, dmag_y2_reg;
    pt_side_t          side2_reg;
    pt_side_t          side2_next;

    assign zsum   = {1'b0, prod1_reg} + (PROD_W + 1)'(128);
    assign z_next = zsum[Z_W+7:8];

    always_comb begin
        side2_next   = side1_reg;
        side2_next.z = z_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg && (z_next != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            dmag_x2_reg <= dmag_x1_reg;
            dmag_y2_reg <= dmag_y1_reg;
            side2_reg   <= side2_next;
        end
    end

    // ---- stage 3: offset times depth ----
    logic [MUL_W-1:0] nx3_reg, ny3_reg;
    pt_side_t         side3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            nx3_reg   <= MUL_W'(dmag_x2_reg) * MUL_W'(side2_reg.z);
            ny3_reg   <= MUL_W'(dmag_y2_reg) * MUL_W'(side2_reg.z);
            side3_reg <= side2_reg;
        end
    end

    // ---- stage 4: add half the divisor for round to nearest ----
    div_stage_t div4_reg;
    div_stage_t div4_next;

    always_comb begin
        div4_next.x.acc = {1'b0, nx3_reg} + NUM_W'(fx_eff >> 1);
        div4_next.x.rem = '0;
        div4_next.y.acc = {1'b0, ny3_reg} + NUM_W'(fy_eff >> 1);
        div4_next.y.rem = '0;
        div4_next.side  = side3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            div4_reg <= div4_next;
        end
    end

    assign div_in = div4_reg;

    dpbp_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .focal_x   (fx_eff),
        .focal_y   (fy_eff),
        .in_valid  (v4_reg),
        .in_ready  (div_in_ready),
        .in_data   (div_in),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_data  (div_out)
    );

    // ---- output: saturate, apply sign, pack ----
    function automatic logic [XY_W-1:0] sat_axis(logic [NUM_W-1:0] q, logic neg);
        logic [NUM_W-1:0] qs;
        if (neg) begin
            qs = (q > XY_NEG_MAG) ? XY_NEG_MAG : q;
            return XY_W'(NUM_W'(0) - qs);
        end
        qs = (q > XY_POS_MAX) ? XY_POS_MAX : q;
        return qs[XY_W-1:0];
    endfunction

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    assign div_out_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_data_next = {(M_TDATA_W - M_USED_W)'(0),
                       div_out.side.blue,
                       div_out.side.green,
                       div_out.side.red,
                       div_out.side.z,
                       sat_axis(div_out.y.acc, div_out.side.neg_y),
                       sat_axis(div_out.x.acc, div_out.side.neg_x)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (div_out_ready) begin
            m_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_out_ready && div_out_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---- checks ----
    a_no_zero_depth_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*XY_W+Z_W-1:2*XY_W] != '0))
        else $error("point with zero depth delivered");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register is empty");

    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule
